// ===== src/dttf_pkg.sv =====
// ----------------------------------------------------------------------------
// dttf_pkg
// Shared types and constants for the depth-tested triangle fill block.
// ----------------------------------------------------------------------------
package dttf_pkg;

  localparam int COORD_W    = 12;  // vertex column and row
  localparam int ZIN_W      = 16;  // vertex depth, Q2.13
  localparam int COLOR_W    = 8;
  localparam int XW         = 13;  // internal row and column, one bit of headroom
  localparam int VW         = 17;  // interpolated edge value (column or depth)
  localparam int ACC_W      = 34;  // depth with 16 fraction bits, step and dividend
  localparam int DVS_W      = 14;  // divisor of the edge and span divisions
  localparam int LIM_W      = 11;  // visible width or height
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS    = 1'd1;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [COORD_W-1:0] vertex_a_x;
    logic signed [COORD_W-1:0] vertex_a_y;
    logic signed [ZIN_W-1:0]   vertex_a_depth;
    logic signed [COORD_W-1:0] vertex_b_x;
    logic signed [COORD_W-1:0] vertex_b_y;
    logic signed [ZIN_W-1:0]   vertex_b_depth;
    logic signed [COORD_W-1:0] vertex_c_x;
    logic signed [COORD_W-1:0] vertex_c_y;
    logic signed [ZIN_W-1:0]   vertex_c_depth;
    logic [COLOR_W-1:0]        paint_color;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0]      pixel_color;
    logic                    pixel_written;
    logic signed [ZIN_W-1:0] pixel_depth;
  } out_item_t;

  // Command after classification: vertices sorted by row, read address kept apart.
  typedef struct packed {
    logic [1:0]                   mode;
    logic [2:0][COORD_W-1:0]      vx;
    logic [2:0][COORD_W-1:0]      vy;
    logic [2:0][ZIN_W-1:0]        vz;
    logic [COLOR_W-1:0]           color;
    logic signed [COORD_W-1:0]    px;
    logic signed [COORD_W-1:0]    py;
  } cmd_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] dividend;
    logic signed [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_RDATA,
    ST_ROW,
    ST_LMUL,
    ST_LDIV,
    ST_LWAIT,
    ST_SPAN,
    ST_STEP,
    ST_SWAIT,
    ST_PIX,
    ST_PWR
  } back_state_t;

endpackage

// ===== src/dttf_front.sv =====
// ----------------------------------------------------------------------------
// dttf_front
// Classifies an incoming item: sorts the three vertices by row.
// ----------------------------------------------------------------------------
module dttf_front (
  input  dttf_pkg::in_item_t item,
  output dttf_pkg::cmd_t     cmd
);
  import dttf_pkg::*;

  logic [2:0][COORD_W-1:0] sx;
  logic [2:0][COORD_W-1:0] sy;
  logic [2:0][ZIN_W-1:0]   sz;
  logic [COORD_W-1:0]      tx;
  logic [COORD_W-1:0]      ty;
  logic [ZIN_W-1:0]        tz;

  // Three compare-and-swap stages in the fixed order (0,1), (0,2), (1,2);
  // a stage does not swap ties, yet tied vertices can still change order.
  always_comb begin
    tx = '0;
    ty = '0;
    tz = '0;
    sx = {item.vertex_c_x, item.vertex_b_x, item.vertex_a_x};
    sy = {item.vertex_c_y, item.vertex_b_y, item.vertex_a_y};
    sz = {item.vertex_c_depth, item.vertex_b_depth, item.vertex_a_depth};
    if ($signed(sy[0]) > $signed(sy[1])) begin
      tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
      ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
      tz = sz[0]; sz[0] = sz[1]; sz[1] = tz;
    end
    if ($signed(sy[0]) > $signed(sy[2])) begin
      tx = sx[0]; sx[0] = sx[2]; sx[2] = tx;
      ty = sy[0]; sy[0] = sy[2]; sy[2] = ty;
      tz = sz[0]; sz[0] = sz[2]; sz[2] = tz;
    end
    if ($signed(sy[1]) > $signed(sy[2])) begin
      tx = sx[1]; sx[1] = sx[2]; sx[2] = tx;
      ty = sy[1]; sy[1] = sy[2]; sy[2] = ty;
      tz = sz[1]; sz[1] = sz[2]; sz[2] = tz;
    end
    cmd.mode  = item.mode;
    cmd.vx    = sx;
    cmd.vy    = sy;
    cmd.vz    = sz;
    cmd.color = item.paint_color;
    cmd.px    = item.vertex_a_x;
    cmd.py    = item.vertex_a_y;
  end

endmodule

// ===== src/dttf_fifo.sv =====
// ----------------------------------------------------------------------------
// dttf_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module dttf_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  dttf_pkg::cmd_t wr_data,
  input  logic           rd,
  output dttf_pkg::cmd_t rd_data,
  output logic           full,
  output logic           empty
);
  import dttf_pkg::*;

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int NW = $clog2(CMDQ_DEPTH + 1);

  cmd_t            entries [CMDQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == NW'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== src/dttf_div.sv =====
// ----------------------------------------------------------------------------
// dttf_div
// Signed divider truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dttf_div (
  input  logic               clk,
  input  logic               rst,
  input  dttf_pkg::div_req_t req,
  output dttf_pkg::div_rsp_t rsp
);
  import dttf_pkg::*;

  localparam int SW = $clog2(ACC_W);

  logic             busy;
  logic             done;
  logic [SW-1:0]    cnt;
  logic [ACC_W-1:0] q;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dmag;
  logic             neg;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem, q[ACC_W-1]};
  assign fits  = (trial >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SW'(ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q    <= (req.dividend < 0) ? ACC_W'(-req.dividend) : ACC_W'(req.dividend);
      dmag <= (req.divisor < 0) ? DVS_W'(-req.divisor) : DVS_W'(req.divisor);
      rem  <= '0;
      neg  <= (req.dividend < 0) ^ (req.divisor < 0);
    end else if (busy) begin
      q   <= {q[ACC_W-2:0], fits};
      rem <= fits ? DVS_W'(trial - {1'b0, dmag}) : trial[DVS_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? -$signed(q) : $signed(q);

endmodule

// ===== src/dttf_back.sv =====
// ----------------------------------------------------------------------------
// dttf_back
// Carries out commands: clear sweep, edge and span walk with depth test,
// pixel read. Holds the depth and colour stores and the result register.
// ----------------------------------------------------------------------------
module dttf_back #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 128,
  parameter int DEPTH_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [dttf_pkg::CFG_DATA_W-1:0]    screen_columns,
  input  logic [dttf_pkg::CFG_DATA_W-2:0]    screen_rows,
  input  dttf_pkg::cmd_t                     cmd_head,
  input  logic                               cmd_empty,
  output logic                               cmd_pop,
  output logic                               init_busy,
  output dttf_pkg::out_item_t                result,
  output logic                               empty,
  input  logic                               pop
);
  import dttf_pkg::*;

  localparam int ZW   = (DEPTH_BITS > ZIN_W) ? DEPTH_BITS : ZIN_W;
  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int NPIX = MAX_COLUMNS * MAX_ROWS;
  localparam int AW   = $clog2(NPIX);
  localparam logic signed [ZW-1:0] DMAX = ZW'((64'(1) << (DEPTH_BITS - 1)) - 64'(1));

  back_state_t state;
  back_state_t state_next;

  cmd_t                     cmd;
  logic                     half;
  logic signed [XW-1:0]     y;
  logic [1:0]               k;
  logic signed [VW-1:0]     res [4];
  logic signed [ACC_W-1:0]  prod;
  logic signed [DVS_W-1:0]  den;
  logic signed [VW-1:0]     lva;
  logic signed [XW-1:0]     xs;
  logic signed [XW-1:0]     xe;
  logic signed [VW-1:0]     zs;
  logic signed [VW-1:0]     ze;
  logic signed [ACC_W-1:0]  step;
  logic signed [ACC_W-1:0]  acc;
  logic signed [XW-1:0]     x;
  logic [AW-1:0]            clr_addr;
  logic                     init_pass;
  logic                     out_valid;
  out_item_t                out_data;

  logic signed [ZW-1:0]     depth_mem [NPIX];
  logic [COLOR_W-1:0]       color_mem [NPIX];
  logic signed [ZW-1:0]     rd_depth;
  logic [COLOR_W-1:0]       rd_color;

  logic                     depth_we;
  logic                     color_we;
  logic                     mem_re;
  logic [AW-1:0]            mem_wa;
  logic [AW-1:0]            mem_ra;
  logic signed [ZW-1:0]     depth_wd;
  logic [COLOR_W-1:0]       color_wd;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic                     take;
  logic                     finish_zero;
  logic [LIM_W-1:0]         cols_lim;
  logic [LIM_W-1:0]         rows_lim;
  logic signed [XW-1:0]     cols_end;
  logic signed [XW-1:0]     hi;
  logic signed [XW-1:0]     yq;
  logic                     row_visible;
  logic                     read_visible;
  logic                     clr_last;
  logic [1:0]               p_idx;
  logic [1:0]               q_idx;
  logic signed [XW-1:0]     lya;
  logic signed [XW-1:0]     lyb;
  logic signed [VW-1:0]     lv_a;
  logic signed [VW-1:0]     lv_b;
  logic signed [VW:0]       ldiff;
  logic signed [XW:0]       ldy;
  logic signed [31:0]       lprod;
  logic signed [VW:0]       dz;
  logic signed [VW:0]       z_pix;
  logic                     z_wins;
  logic [AW-1:0]            pix_addr;
  logic [AW-1:0]            read_addr;
  logic                     span_swap;

  dttf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Visible limits and small decodes.
  assign cols_lim = (LIM_W'(screen_columns) < LIM_W'(MAX_COLUMNS)) ?
                    LIM_W'(screen_columns) : LIM_W'(MAX_COLUMNS);
  assign rows_lim = (LIM_W'(screen_rows) < LIM_W'(MAX_ROWS)) ?
                    LIM_W'(screen_rows) : LIM_W'(MAX_ROWS);
  assign cols_end = $signed({2'b00, cols_lim}) - XW'(1);
  assign hi       = (xe < cols_end) ? xe : cols_end;
  assign p_idx    = {1'b0, half};
  assign q_idx    = p_idx + 2'd1;
  assign yq       = XW'($signed(cmd.vy[q_idx]));
  assign row_visible  = (y >= 0) && (y < $signed({2'b00, rows_lim}));
  assign read_visible = (cmd.px >= 0) && (XW'(cmd.px) < $signed({2'b00, cols_lim})) &&
                        (cmd.py >= 0) && (XW'(cmd.py) < $signed({2'b00, rows_lim}));
  assign clr_last = (clr_addr == AW'(NPIX - 1));
  assign take     = (state == ST_IDLE) && !cmd_empty && !out_valid;

  assign pix_addr  = AW'(y[RW-1:0]) * AW'(MAX_COLUMNS) + AW'(x[CW-1:0]);
  assign read_addr = AW'(cmd.py[RW-1:0]) * AW'(MAX_COLUMNS) + AW'(cmd.px[CW-1:0]);

  // Operands of the current edge interpolation: even k is the long edge.
  always_comb begin
    lya  = k[0] ? XW'($signed(cmd.vy[p_idx])) : XW'($signed(cmd.vy[0]));
    lyb  = k[0] ? yq : XW'($signed(cmd.vy[2]));
    lv_a = '0;
    lv_b = '0;
    case (k)
      2'd0: begin
        lv_a = VW'($signed(cmd.vx[0]));
        lv_b = VW'($signed(cmd.vx[2]));
      end
      2'd1: begin
        lv_a = VW'($signed(cmd.vx[p_idx]));
        lv_b = VW'($signed(cmd.vx[q_idx]));
      end
      2'd2: begin
        lv_a = VW'($signed(cmd.vz[0]));
        lv_b = VW'($signed(cmd.vz[2]));
      end
      default: begin
        lv_a = VW'($signed(cmd.vz[p_idx]));
        lv_b = VW'($signed(cmd.vz[q_idx]));
      end
    endcase
    ldiff = (VW+1)'(lv_b) - (VW+1)'(lv_a);
    ldy   = (XW+1)'(y) - (XW+1)'(lya);
    lprod = ldiff * ldy;
  end

  assign span_swap = (XW'(res[0]) > XW'(res[1]));
  assign dz        = (VW+1)'(ze) - (VW+1)'(zs);
  assign z_pix     = $signed(acc[ACC_W-1:16]);
  assign z_wins    = (z_pix < rd_depth);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          unique case (cmd_head.mode)
            MODE_CLEAR: state_next = ST_CLEAR;
            MODE_DRAW:  state_next = ST_ROW;
            MODE_READ:  state_next = ST_READ;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_READ:  state_next = read_visible ? ST_RDATA : ST_IDLE;
      ST_RDATA: state_next = ST_IDLE;
      ST_ROW: begin
        if (y > yq) begin
          state_next = half ? ST_IDLE : ST_ROW;
        end else if (row_visible) begin
          state_next = ST_LMUL;
        end
      end
      ST_LMUL:  state_next = ST_LDIV;
      ST_LDIV: begin
        if (den != 0) begin
          state_next = ST_LWAIT;
        end else begin
          state_next = (k == 2'd3) ? ST_SPAN : ST_LMUL;
        end
      end
      ST_LWAIT: if (div_rsp.done) state_next = (k == 2'd3) ? ST_SPAN : ST_LMUL;
      ST_SPAN:  state_next = ST_STEP;
      ST_STEP:  state_next = (xe == xs) ? ST_PIX : ST_SWAIT;
      ST_SWAIT: if (div_rsp.done) state_next = ST_PIX;
      ST_PIX: begin
        if (x > hi) begin
          state_next = ST_ROW;
        end else if (x >= 0) begin
          state_next = ST_PWR;
        end
      end
      ST_PWR:   state_next = ST_PIX;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory strobes, divider requests, completion.
  always_comb begin
    cmd_pop          = take;
    depth_we         = 1'b0;
    color_we         = 1'b0;
    mem_re           = 1'b0;
    mem_wa           = pix_addr;
    mem_ra           = pix_addr;
    depth_wd         = DMAX;
    color_wd         = cmd.color;
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = den;
    finish_zero      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        finish_zero = take && (cmd_head.mode != MODE_CLEAR) &&
                      (cmd_head.mode != MODE_DRAW) && (cmd_head.mode != MODE_READ);
      end
      ST_CLEAR: begin
        depth_we    = 1'b1;
        color_we    = init_pass;
        mem_wa      = clr_addr;
        color_wd    = '0;
        finish_zero = clr_last && !init_pass;
      end
      ST_READ: begin
        mem_re      = read_visible;
        mem_ra      = read_addr;
        finish_zero = !read_visible;
      end
      ST_ROW: begin
        finish_zero = (y > yq) && half;
      end
      ST_LDIV: begin
        div_req.start = (den != 0);
      end
      ST_STEP: begin
        div_req.start    = (xe != xs);
        div_req.dividend = ACC_W'(dz) <<< 16;
        div_req.divisor  = DVS_W'(xe) - DVS_W'(xs);
      end
      ST_PIX: begin
        mem_re = (x <= hi) && (x >= 0);
      end
      ST_PWR: begin
        depth_we = z_wins;
        color_we = z_wins;
        depth_wd = ZW'(z_pix);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      init_pass <= 1'b1;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
        if (clr_last) begin
          init_pass <= 1'b0;
        end
      end
      if (finish_zero || (state == ST_RDATA)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk datapath.
  always_ff @(posedge clk) begin
    if (take) begin
      cmd  <= cmd_head;
      half <= 1'b0;
      y    <= XW'($signed(cmd_head.vy[0]));
    end
    if (finish_zero) begin
      out_data <= '0;
    end else if (state == ST_RDATA) begin
      out_data.pixel_color   <= rd_color;
      out_data.pixel_written <= (rd_depth != DMAX);
      out_data.pixel_depth   <= rd_depth[ZIN_W-1:0];
    end
    unique case (state)
      ST_ROW: begin
        if (y > yq) begin
          if (!half) begin
            half <= 1'b1;
            y    <= XW'($signed(cmd.vy[1]));
          end
        end else if (!row_visible) begin
          y <= y + XW'(1);
        end else begin
          k <= 2'd0;
        end
      end
      ST_LMUL: begin
        prod <= ACC_W'(lprod);
        den  <= DVS_W'(lyb) - DVS_W'(lya);
        lva  <= lv_a;
      end
      ST_LDIV: begin
        if (den == 0) begin
          res[k] <= lva;
          k      <= k + 2'd1;
        end
      end
      ST_LWAIT: begin
        if (div_rsp.done) begin
          res[k] <= lva + VW'(div_rsp.quotient);
          k      <= k + 2'd1;
        end
      end
      ST_SPAN: begin
        xs <= span_swap ? XW'(res[1]) : XW'(res[0]);
        xe <= span_swap ? XW'(res[0]) : XW'(res[1]);
        zs <= span_swap ? res[3] : res[2];
        ze <= span_swap ? res[2] : res[3];
      end
      ST_STEP: begin
        if (xe == xs) begin
          step <= '0;
          acc  <= ACC_W'(zs) <<< 16;
          x    <= xs;
        end
      end
      ST_SWAIT: begin
        if (div_rsp.done) begin
          step <= div_rsp.quotient;
          acc  <= ACC_W'(zs) <<< 16;
          x    <= xs;
        end
      end
      ST_PIX: begin
        if (x > hi) begin
          y <= y + XW'(1);
        end else if (x < 0) begin
          acc <= acc + step;
          x   <= x + XW'(1);
        end
      end
      ST_PWR: begin
        acc <= acc + step;
        x   <= x + XW'(1);
      end
      default: begin
      end
    endcase
  end

  // Depth and colour stores: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (depth_we) begin
      depth_mem[mem_wa] <= depth_wd;
    end
    if (mem_re) begin
      rd_depth <= depth_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (color_we) begin
      color_mem[mem_wa] <= color_wd;
    end
    if (mem_re) begin
      rd_color <= color_mem[mem_ra];
    end
  end

  assign init_busy = init_pass;
  assign result    = out_data;
  assign empty     = !out_valid;

endmodule

// ===== src/depth_tested_triangle_fill.sv =====
// ----------------------------------------------------------------------------
// depth_tested_triangle_fill
// Depth-tested triangle rasteriser with clear, draw and pixel read commands.
//
//   channel   handshake          payload
//   input     push / full        item   (in_item_t)
//   result    empty / pop        result (out_item_t)
//   config    cfg_write          cfg_index, cfg_data
//
// Each command yields one result. Clear sweeps the depth store over all
// MAX_COLUMNS * MAX_ROWS addresses; a read returns one pixel, or zero when it
// lies off the visible screen. A draw steps past rows off screen one by one,
// runs the column and depth divisions of both edges and the depth step division on each visible row,
// does a depth read-modify-write for each visible pixel and steps past columns
// clipped on the left. After reset the stores are swept over all addresses with
// full held high. Two commands queue up while the back end works or a result waits to be transferred.
// ----------------------------------------------------------------------------
module depth_tested_triangle_fill #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 128,
  parameter int DEPTH_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  dttf_pkg::in_item_t                  item,
  output logic                                empty,
  input  logic                                pop,
  output dttf_pkg::out_item_t                 result,
  input  logic                                cfg_write,
  input  logic [dttf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dttf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dttf_pkg::*;

  logic [CFG_DATA_W-1:0] screen_columns;
  logic [CFG_DATA_W-2:0] screen_rows;
  cmd_t                  front_cmd;
  cmd_t                  head_cmd;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic                  init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= CFG_DATA_W'(256);
      screen_rows    <= (CFG_DATA_W-1)'(128);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCREEN_COLUMNS: screen_columns <= cfg_data;
        REG_SCREEN_ROWS:    screen_rows    <= cfg_data[CFG_DATA_W-2:0];
        default: begin
        end
      endcase
    end
  end

  assign full = q_full || init_busy;

  dttf_front u_front (
    .item (item),
    .cmd  (front_cmd)
  );

  dttf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (push && !full),
    .wr_data (front_cmd),
    .rd      (q_pop),
    .rd_data (head_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  dttf_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .screen_columns (screen_columns),
    .screen_rows    (screen_rows),
    .cmd_head       (head_cmd),
    .cmd_empty      (q_empty),
    .cmd_pop        (q_pop),
    .init_busy      (init_busy),
    .result         (result),
    .empty          (empty),
    .pop            (pop)
  );

endmodule
